// ===== rtl/core/dc_motor_plant_rk4_step_macros.svh =====
// ----------------------------------------------------------------------------
// dc_motor_plant_rk4_step assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef DC_MOTOR_PLANT_RK4_STEP_MACROS_SVH
`define DC_MOTOR_PLANT_RK4_STEP_MACROS_SVH

// same-cycle implication
`define DCMRK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dcmrk assertion failed");

// next-cycle implication
`define DCMRK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dcmrk assertion failed");

`endif

// ===== rtl/core/dcmrk_pkg.sv =====
// ----------------------------------------------------------------------------
// dcmrk_pkg
// types, constants and helpers of the dc motor rk4 plant
// ----------------------------------------------------------------------------
package dcmrk_pkg;

    localparam int DT_SHIFT   = 20;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int DUTY_W     = 14;
    localparam int ACC_W      = 62;
    localparam int DIV_W      = 56;
    localparam int DIV_DIGIT  = 8;
    localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int LAST_STAGE = 3;
    localparam int FULL_STAGE = 2;
    localparam logic signed [15:0] DUTY_MAX = 16'sd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUS_VOLTAGE = 3'd0,
        CFG_RESISTANCE  = 3'd1,
        CFG_INV_L       = 3'd2,
        CFG_KE          = 3'd3,
        CFG_KT          = 3'd4,
        CFG_DAMPING     = 3'd5,
        CFG_LOAD        = 3'd6,
        CFG_INV_J       = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_DRIVE = 3'd0,
        ST_RES   = 3'd1,
        ST_EMF   = 3'd2,
        ST_TRQ   = 3'd3,
        ST_DAMP  = 3'd4,
        ST_DI    = 3'd5,
        ST_DW    = 3'd6,
        ST_DRAIN = 3'd7
    } t_step;

    typedef enum logic [1:0] {
        DV_CUR = 2'd0,
        DV_SPD = 2'd1,
        DV_ANG = 2'd2
    } t_div_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SLOPE,
        S_DSTART,
        S_DWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     load;
        logic     slope;
        t_step    step;
        logic [1:0] stage;
        logic     div_start;
        logic     div_store;
        t_div_sel div_sel;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_stat;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh000000007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sh0000000080000000) begin
            r = -32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [DUTY_W-1:0] limit_duty(input logic signed [15:0] d);
        logic signed [15:0] r;
        if (d > DUTY_MAX) begin
            r = DUTY_MAX;
        end else if (d < -DUTY_MAX) begin
            r = -DUTY_MAX;
        end else begin
            r = d;
        end
        return r[DUTY_W-1:0];
    endfunction

endpackage

// ===== rtl/core/dcmrk_in_if.sv =====
// ----------------------------------------------------------------------------
// dcmrk_in_if
// step channel carrying the three duty samples
// ----------------------------------------------------------------------------
interface dcmrk_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] duty_start;
    logic signed [15:0] duty_mid;
    logic signed [15:0] duty_end;

    modport source(output valid, duty_start, duty_mid, duty_end, input ready);
    modport sink(input valid, duty_start, duty_mid, duty_end, output ready);
endinterface

// ===== rtl/core/dcmrk_out_if.sv =====
// ----------------------------------------------------------------------------
// dcmrk_out_if
// result channel carrying the plant state and derived values
// ----------------------------------------------------------------------------
interface dcmrk_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] current_now;
    logic signed [31:0] speed_now;
    logic signed [47:0] angle_now;
    logic signed [31:0] torque_now;
    logic signed [31:0] emf_now;
    logic signed [31:0] drive_voltage;
    logic signed [13:0] duty_applied;

    modport source(output valid, current_now, speed_now, angle_now, torque_now,
                   emf_now, drive_voltage, duty_applied, input ready);
    modport sink(input valid, current_now, speed_now, angle_now, torque_now,
                 emf_now, drive_voltage, duty_applied, output ready);
endinterface

// ===== rtl/core/dcmrk_div3.sv =====
// ----------------------------------------------------------------------------
// dcmrk_div3
// sequential floor division by three, eight quotient bits per cycle
// ----------------------------------------------------------------------------
module dcmrk_div3 import dcmrk_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIV_W-1:0] i_num,
    output logic                    o_done,
    output logic signed [DIV_W-1:0] o_quot
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_num, n_num;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [1:0]           r_rem, n_rem;
    logic                 r_neg, n_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_neg <= n_neg;
    end

    always_comb begin
        logic [2:0]           rem3;
        logic [1:0]           rem;
        logic [DIV_DIGIT-1:0] qbits;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_neg  = r_neg;
        rem    = r_rem;
        qbits  = '0;
        for (int j = 0; j < DIV_DIGIT; j++) begin
            rem3 = {rem, r_num[DIV_W-1-j]};
            if (rem3 >= 3'd3) begin
                rem3 = rem3 - 3'd3;
                qbits[DIV_DIGIT-1-j] = 1'b1;
            end
            rem = rem3[1:0];
        end
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = '0;
            n_neg  = i_num[DIV_W-1];
            // floor for negatives: -floor((2 - x) / 3)
            n_num  = i_num[DIV_W-1] ? DIV_W'(-i_num + DIV_W'(2)) : i_num;
        end else if (r_busy) begin
            n_rem = rem;
            n_quo = {r_quo[DIV_W-DIV_DIGIT-1:0], qbits};
            n_num = r_num << DIV_DIGIT;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

// ===== rtl/core/dcmrk_datapath.sv =====
// ----------------------------------------------------------------------------
// dcmrk_datapath
// config registers, plant state, shared multiplier, rk4 accumulation
// ----------------------------------------------------------------------------
module dcmrk_datapath import dcmrk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic signed [15:0]    i_duty_start,
    input  logic signed [15:0]    i_duty_mid,
    input  logic signed [15:0]    i_duty_end,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    dcmrk_out_if.source           o_res
);

    logic [15:0]        r_vbus, r_res, r_ke, r_kt;
    logic [23:0]        r_inv_l, r_damp;
    logic signed [23:0] r_tl;
    logic [31:0]        r_inv_j;

    logic signed [31:0] r_cur, n_cur, r_spd, n_spd;
    logic [47:0]        r_ang, n_ang;
    logic signed [31:0] r_ti, n_ti, r_tw, n_tw;
    logic signed [DUTY_W-1:0] r_d0, n_d0, r_d1, n_d1, r_d2, n_d2;
    logic signed [39:0] r_vnet, n_vnet;
    logic signed [35:0] r_tnet, n_tnet;
    logic signed [ACC_W-1:0] r_acc_i, n_acc_i, r_acc_w, n_acc_w;
    logic signed [35:0] r_acc_a, n_acc_a;
    logic signed [65:0] r_prod, n_prod;
    logic signed [31:0] r_drv, n_drv, r_emf, n_emf, r_trq, n_trq;
    logic signed [DIV_W-1:0] r_q_i, n_q_i, r_q_w, n_q_w, r_q_a, n_q_a;
    logic               r_ovalid, n_ovalid;

    logic signed [32:0] mul_a, mul_b;
    logic signed [DIV_W-1:0] div_num, div_quot;
    logic               div_done;

    dcmrk_div3 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbus   <= '0;
            r_res    <= '0;
            r_inv_l  <= '0;
            r_ke     <= '0;
            r_kt     <= '0;
            r_damp   <= '0;
            r_tl     <= '0;
            r_inv_j  <= '0;
            r_cur    <= '0;
            r_spd    <= '0;
            r_ang    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BUS_VOLTAGE: r_vbus  <= i_cfg_data[15:0];
                    CFG_RESISTANCE:  r_res   <= i_cfg_data[15:0];
                    CFG_INV_L:       r_inv_l <= i_cfg_data[23:0];
                    CFG_KE:          r_ke    <= i_cfg_data[15:0];
                    CFG_KT:          r_kt    <= i_cfg_data[15:0];
                    CFG_DAMPING:     r_damp  <= i_cfg_data[23:0];
                    CFG_LOAD:        r_tl    <= i_cfg_data[23:0];
                    CFG_INV_J:       r_inv_j <= i_cfg_data;
                    default: ;
                endcase
            end
            r_cur    <= n_cur;
            r_spd    <= n_spd;
            r_ang    <= n_ang;
            r_ovalid <= n_ovalid;
        end
        r_ti    <= n_ti;
        r_tw    <= n_tw;
        r_d0    <= n_d0;
        r_d1    <= n_d1;
        r_d2    <= n_d2;
        r_vnet  <= n_vnet;
        r_tnet  <= n_tnet;
        r_acc_i <= n_acc_i;
        r_acc_w <= n_acc_w;
        r_acc_a <= n_acc_a;
        r_prod  <= n_prod;
        r_drv   <= n_drv;
        r_emf   <= n_emf;
        r_trq   <= n_trq;
        r_q_i   <= n_q_i;
        r_q_w   <= n_q_w;
        r_q_a   <= n_q_a;
    end

    // multiplier operand select
    always_comb begin
        logic signed [DUTY_W-1:0] duty;
        case (i_cmd.stage)
            2'd0:    duty = r_d0;
            2'd3:    duty = r_d2;
            default: duty = r_d1;
        endcase
        case (i_cmd.step)
            ST_DRIVE: begin
                mul_a = 33'(duty);
                mul_b = $signed({17'd0, r_vbus});
            end
            ST_RES: begin
                mul_a = 33'(r_ti);
                mul_b = $signed({17'd0, r_res});
            end
            ST_EMF: begin
                mul_a = 33'(r_tw);
                mul_b = $signed({17'd0, r_ke});
            end
            ST_TRQ: begin
                mul_a = 33'(r_ti);
                mul_b = $signed({17'd0, r_kt});
            end
            ST_DAMP: begin
                mul_a = 33'(r_tw);
                mul_b = $signed({9'd0, r_damp});
            end
            ST_DI: begin
                mul_a = 33'(sat32(64'(r_vnet)));
                mul_b = $signed({9'd0, r_inv_l});
            end
            ST_DW: begin
                mul_a = 33'(sat32(64'(r_tnet)));
                mul_b = $signed({1'b0, r_inv_j});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.div_sel)
            DV_CUR:  div_num = DIV_W'(r_acc_i >>> (DT_SHIFT + 1));
            DV_SPD:  div_num = DIV_W'(r_acc_w >>> (DT_SHIFT + 1));
            default: div_num = DIV_W'(ACC_W'(r_acc_a) >>> (DT_SHIFT + 1));
        endcase
    end

    always_comb begin
        logic signed [65:0] p4, p12, p16, p24, p8;
        logic signed [57:0] k;
        logic signed [57:0] k_sh;
        logic signed [31:0] base;
        logic signed [31:0] trial;
        logic               dbl;
        logic               first;
        n_cur    = r_cur;
        n_spd    = r_spd;
        n_ang    = r_ang;
        n_ti     = r_ti;
        n_tw     = r_tw;
        n_d0     = r_d0;
        n_d1     = r_d1;
        n_d2     = r_d2;
        n_vnet   = r_vnet;
        n_tnet   = r_tnet;
        n_acc_i  = r_acc_i;
        n_acc_w  = r_acc_w;
        n_acc_a  = r_acc_a;
        n_prod   = r_prod;
        n_drv    = r_drv;
        n_emf    = r_emf;
        n_trq    = r_trq;
        n_q_i    = r_q_i;
        n_q_w    = r_q_w;
        n_q_a    = r_q_a;
        n_ovalid = r_ovalid && !o_res.ready;

        p4    = r_prod >>> 4;
        p8    = r_prod >>> 8;
        p12   = r_prod >>> 12;
        p16   = r_prod >>> 16;
        p24   = r_prod >>> 24;
        k     = p8[57:0];
        k_sh  = (i_cmd.stage == 2'(FULL_STAGE)) ? (k >>> DT_SHIFT) : (k >>> (DT_SHIFT + 1));
        dbl   = (i_cmd.stage == 2'd1) || (i_cmd.stage == 2'd2);
        first = (i_cmd.stage == 2'd0);
        base  = (i_cmd.step == ST_DW) ? r_cur : r_spd;
        trial = sat32(64'(base) + 64'(k_sh));

        if (i_cmd.load) begin
            n_d0    = limit_duty(i_duty_start);
            n_d1    = limit_duty(i_duty_mid);
            n_d2    = limit_duty(i_duty_end);
            n_ti    = r_cur;
            n_tw    = r_spd;
            n_acc_i = '0;
            n_acc_w = '0;
            n_acc_a = '0;
        end

        if (i_cmd.slope) begin
            n_prod = mul_a * mul_b;
            case (i_cmd.step)
                ST_DRIVE: begin
                    n_acc_a = r_acc_a + (dbl ? (36'(r_tw) <<< 1) : 36'(r_tw));
                end
                ST_RES: begin
                    n_vnet = p4[39:0];
                    if (first) n_drv = p4[31:0];
                end
                ST_EMF: begin
                    n_vnet = r_vnet - p12[39:0];
                end
                ST_TRQ: begin
                    n_vnet = r_vnet - p16[39:0];
                    if (first) n_emf = p16[31:0];
                end
                ST_DAMP: begin
                    n_tnet = p16[35:0] - 36'(r_tl);
                    if (first) n_trq = p16[31:0];
                end
                ST_DI: begin
                    n_tnet = r_tnet - p24[35:0];
                end
                ST_DW: begin
                    n_acc_i = r_acc_i + (dbl ? (ACC_W'(k) <<< 1) : ACC_W'(k));
                    n_ti    = trial;
                end
                ST_DRAIN: begin
                    n_acc_w = r_acc_w + (dbl ? (ACC_W'(k) <<< 1) : ACC_W'(k));
                    n_tw    = trial;
                end
                default: ;
            endcase
        end

        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                DV_CUR:  n_q_i = div_quot;
                DV_SPD:  n_q_w = div_quot;
                default: n_q_a = div_quot;
            endcase
        end

        if (i_cmd.commit) begin
            n_cur    = sat32(64'(r_cur) + 64'(r_q_i));
            n_spd    = sat32(64'(r_spd) + 64'(r_q_w));
            n_ang    = r_ang + 48'(r_q_a);
            n_ovalid = 1'b1;
        end
    end

    // result register, loaded with the pre-step state on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_res.current_now   <= r_cur;
            o_res.speed_now     <= r_spd;
            o_res.angle_now     <= $signed(r_ang);
            o_res.torque_now    <= r_trq;
            o_res.emf_now       <= r_emf;
            o_res.drive_voltage <= r_drv;
            o_res.duty_applied  <= r_d0;
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_ovalid || o_res.ready;

endmodule

// ===== rtl/core/dcmrk_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcmrk_ctrl
// sequencer for the four slope stages, the divisions and the commit
// ----------------------------------------------------------------------------
module dcmrk_ctrl import dcmrk_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state     r_state, n_state;
    t_step      r_step, n_step;
    logic [1:0] r_stage, n_stage;
    t_div_sel   r_dsel, n_dsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_DRIVE;
            r_stage <= '0;
            r_dsel  <= DV_CUR;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_stage <= n_stage;
            r_dsel  <= n_dsel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_stage    = r_stage;
        n_dsel     = r_dsel;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.step    = r_step;
        o_cmd.stage   = r_stage;
        o_cmd.div_sel = r_dsel;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = ST_DRIVE;
                    n_stage    = '0;
                    n_state    = S_SLOPE;
                end
            end
            S_SLOPE: begin
                o_cmd.slope = 1'b1;
                n_step      = t_step'(r_step + 3'd1);
                if (r_step == ST_DRAIN) begin
                    n_stage = r_stage + 2'd1;
                    if (r_stage == 2'(LAST_STAGE)) begin
                        n_dsel  = DV_CUR;
                        n_state = S_DSTART;
                    end
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    case (r_dsel)
                        DV_CUR:  begin n_dsel = DV_SPD; n_state = S_DSTART; end
                        DV_SPD:  begin n_dsel = DV_ANG; n_state = S_DSTART; end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/dc_motor_plant_rk4_step.sv =====
// one step at a time: input ready stays low from the input transfer until the result
//   is committed; the slope work runs on the single shared multiplier, followed by
//   three serial divisions by six
// reset: synchronous, clears config, motor state and handshake control to zero
// ----------------------------------------------------------------------------
// dc_motor_plant_rk4_step
// dc motor plant advanced by one fixed point rk4 step per input transfer
// ----------------------------------------------------------------------------
module dc_motor_plant_rk4_step import dcmrk_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    dcmrk_in_if.sink             i_in,
    dcmrk_out_if.source          o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dcmrk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dcmrk_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_duty_start (i_in.duty_start),
        .i_duty_mid   (i_in.duty_mid),
        .i_duty_end   (i_in.duty_end),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_res        (o_res)
    );

endmodule

// ===== rtl/core/dcmrk_checker.sv =====
// ----------------------------------------------------------------------------
// dcmrk_checker
// port level checks of the dc motor rk4 plant
// ----------------------------------------------------------------------------
`include "dc_motor_plant_rk4_step_macros.svh"

module dcmrk_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    `DCMRK_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `DCMRK_ASSERT_NEXT(a_one_in_flight, i_in_valid && i_in_ready, !i_in_ready)
    `DCMRK_ASSERT_NOW(a_result_after_work, $rose(i_out_valid), !$past(i_in_ready))
    `DCMRK_ASSERT_NEXT(a_no_early_result, i_in_valid && i_in_ready && !i_out_valid, !i_out_valid)

endmodule

bind dc_motor_plant_rk4_step dcmrk_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready)
);
